// ===== sv/wtsc_pkg.sv =====
// shared types, codes and constants for the watch time-set controller
// no dependencies; used by every other file in this folder
package wtsc_pkg;

    localparam int TIMER_WIDTH = 20;
    localparam int CFG_WIDTH   = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int HOURS_W     = 5;
    localparam int MINUTES_W   = 6;

    localparam logic [TIMER_WIDTH-1:0] TMR_MAX = {TIMER_WIDTH{1'b1}};

    localparam logic [HOURS_W-1:0]   HOURS_MAX   = HOURS_W'(23);
    localparam logic [MINUTES_W-1:0] MINUTES_MAX = MINUTES_W'(59);

    localparam logic [CFG_WIDTH-1:0] BLINK_RESET   = CFG_WIDTH'(500);
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = CFG_WIDTH'(30000);
    localparam logic [CFG_WIDTH-1:0] CONFIRM_RESET = CFG_WIDTH'(2000);

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_HOURS   = 2'd1,
        MODE_MINUTES = 2'd2,
        MODE_CONFIRM = 2'd3
    } mode_t;

    localparam logic [1:0] BTN_UP     = 2'd0;
    localparam logic [1:0] BTN_SELECT = 2'd1;
    localparam logic [1:0] BTN_DOWN   = 2'd2;

    localparam logic REQ_BUTTON = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 2'd2;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] blink_ticks;
        logic [CFG_WIDTH-1:0] timeout_ticks;
        logic [CFG_WIDTH-1:0] confirm_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 handled;
        mode_t                mode;
        logic [HOURS_W-1:0]   shown_hours;
        logic [MINUTES_W-1:0] shown_minutes;
        logic                 blank_hours;
        logic                 blank_minutes;
        logic                 clock_write;
        logic                 show_clock;
        logic                 redraw;
    } result_t;

endpackage

// ===== sv/wtsc_req_if.sv =====
// request channel: button events and timer ticks
// depends on wtsc_pkg
interface wtsc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [1:0]                    button;
    logic                          long_press;
    logic [wtsc_pkg::HOURS_W-1:0]   clock_hours;
    logic [wtsc_pkg::MINUTES_W-1:0] clock_minutes;

    modport source (
        output valid, req_type, button, long_press, clock_hours, clock_minutes,
        input  ready
    );
    modport sink (
        input  valid, req_type, button, long_press, clock_hours, clock_minutes,
        output ready
    );
endinterface

// ===== sv/wtsc_res_if.sv =====
// result channel: mode, working time and display/clock flags
// depends on wtsc_pkg
interface wtsc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          handled;
    logic [1:0]                    mode;
    logic [wtsc_pkg::HOURS_W-1:0]   shown_hours;
    logic [wtsc_pkg::MINUTES_W-1:0] shown_minutes;
    logic                          blank_hours;
    logic                          blank_minutes;
    logic                          clock_write;
    logic                          show_clock;
    logic                          redraw;

    modport source (
        output valid, handled, mode, shown_hours, shown_minutes, blank_hours,
               blank_minutes, clock_write, show_clock, redraw,
        input  ready
    );
    modport sink (
        input  valid, handled, mode, shown_hours, shown_minutes, blank_hours,
               blank_minutes, clock_write, show_clock, redraw,
        output ready
    );
    modport monitor (
        input valid, ready, handled, mode, shown_hours, shown_minutes, blank_hours,
              blank_minutes, clock_write, show_clock, redraw
    );
endinterface

// ===== sv/watch_time_set_controller_unit.sv =====
// result: registered; valid rises in the cycle after a request transfer
// throughput: one request per cycle unless a result stalls; the slot refills as it drains
// the mode machine and tick counters update in one pass, so state is ready for the next item
// reset: asynchronous active-low; normal mode, working time and counters zero,
// thresholds back to 500, 30000 and 2000 ticks
module watch_time_set_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    wtsc_req_if.sink                            req,
    wtsc_res_if.source                          res,
    input  logic                                cfg_we,
    input  logic [wtsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtsc_pkg::CFG_WIDTH-1:0]      cfg_data
);

    // threshold registers
    wtsc_pkg::cfg_t    cfg_reg;

    // result register and its valid flag
    wtsc_pkg::result_t res_reg;
    logic              res_valid_reg;

    wtsc_pkg::result_t core_result;
    logic              req_xfer;

    // take a new request whenever the result slot is empty or draining this cycle
    assign req.ready = !res_valid_reg || res.ready;
    assign req_xfer  = req.valid && req.ready;

    // configuration writes; an index past the last register is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_ticks   <= wtsc_pkg::BLINK_RESET;
            cfg_reg.timeout_ticks <= wtsc_pkg::TIMEOUT_RESET;
            cfg_reg.confirm_ticks <= wtsc_pkg::CONFIRM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wtsc_pkg::CFG_BLINK:   cfg_reg.blink_ticks   <= cfg_data;
                wtsc_pkg::CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                wtsc_pkg::CFG_CONFIRM: cfg_reg.confirm_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // mode machine; state advances only on a request transfer
    wtsc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (req_xfer),
        .req_type      (req.req_type),
        .button        (req.button),
        .long_press    (req.long_press),
        .clock_hours   (req.clock_hours),
        .clock_minutes (req.clock_minutes),
        .cfg           (cfg_reg),
        .result        (core_result)
    );

    // valid flag: set by a request transfer, cleared when the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (req_xfer)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            res_reg <= core_result;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.handled       = res_reg.handled;
    assign res.mode          = res_reg.mode;
    assign res.shown_hours   = res_reg.shown_hours;
    assign res.shown_minutes = res_reg.shown_minutes;
    assign res.blank_hours   = res_reg.blank_hours;
    assign res.blank_minutes = res_reg.blank_minutes;
    assign res.clock_write   = res_reg.clock_write;
    assign res.show_clock    = res_reg.show_clock;
    assign res.redraw        = res_reg.redraw;

endmodule

// ===== sv/wtsc_core.sv =====
// mode machine, working time and tick counters of the time-set controller
// depends on wtsc_pkg
module wtsc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            req_type,
    input  logic [1:0]                      button,
    input  logic                            long_press,
    input  logic [wtsc_pkg::HOURS_W-1:0]    clock_hours,
    input  logic [wtsc_pkg::MINUTES_W-1:0]  clock_minutes,
    input  wtsc_pkg::cfg_t                  cfg,
    output wtsc_pkg::result_t               result
);

    wtsc_pkg::mode_t                   mode_reg, mode_next;
    logic [wtsc_pkg::HOURS_W-1:0]      hours_reg, hours_next;
    logic [wtsc_pkg::MINUTES_W-1:0]    minutes_reg, minutes_next;
    logic                              phase_reg, phase_next;
    logic [wtsc_pkg::TIMER_WIDTH-1:0]  blink_cnt_reg, blink_cnt_next;
    logic [wtsc_pkg::TIMER_WIDTH-1:0]  idle_cnt_reg, idle_cnt_next;
    logic [wtsc_pkg::TIMER_WIDTH-1:0]  hold_cnt_reg, hold_cnt_next;

    logic [wtsc_pkg::TIMER_WIDTH-1:0]  blink_inc, idle_inc, hold_inc;
    logic                              blink_fire, idle_fire, hold_fire;
    logic                              handled, wr, showc, redraw;

    // saturating increments and their threshold checks
    always_comb
    begin
        blink_inc = (blink_cnt_reg != wtsc_pkg::TMR_MAX) ? blink_cnt_reg + 1'b1
                                                          : blink_cnt_reg;
        idle_inc  = (idle_cnt_reg != wtsc_pkg::TMR_MAX) ? idle_cnt_reg + 1'b1
                                                         : idle_cnt_reg;
        hold_inc  = (hold_cnt_reg != wtsc_pkg::TMR_MAX) ? hold_cnt_reg + 1'b1
                                                         : hold_cnt_reg;
        blink_fire = (blink_inc >= cfg.blink_ticks)   || (blink_inc == wtsc_pkg::TMR_MAX);
        idle_fire  = (idle_inc  >= cfg.timeout_ticks) || (idle_inc  == wtsc_pkg::TMR_MAX);
        hold_fire  = (hold_inc  >= cfg.confirm_ticks) || (hold_inc  == wtsc_pkg::TMR_MAX);
    end

    always_comb
    begin
        mode_next      = mode_reg;
        hours_next     = hours_reg;
        minutes_next   = minutes_reg;
        phase_next     = phase_reg;
        blink_cnt_next = blink_cnt_reg;
        idle_cnt_next  = idle_cnt_reg;
        hold_cnt_next  = hold_cnt_reg;
        handled        = 1'b0;
        wr             = 1'b0;
        showc          = 1'b0;
        redraw         = 1'b0;

        if (req_type == wtsc_pkg::REQ_BUTTON)
        begin
            if (mode_reg == wtsc_pkg::MODE_NORMAL)
            begin
                if (button == wtsc_pkg::BTN_SELECT && long_press)
                begin
                    hours_next     = (clock_hours > wtsc_pkg::HOURS_MAX) ?
                                     wtsc_pkg::HOURS_MAX : clock_hours;
                    minutes_next   = (clock_minutes > wtsc_pkg::MINUTES_MAX) ?
                                     wtsc_pkg::MINUTES_MAX : clock_minutes;
                    phase_next     = 1'b1;
                    blink_cnt_next = '0;
                    idle_cnt_next  = '0;
                    hold_cnt_next  = '0;
                    mode_next      = wtsc_pkg::MODE_HOURS;
                    handled        = 1'b1;
                    redraw         = 1'b1;
                end
            end
            else if (mode_reg == wtsc_pkg::MODE_CONFIRM || long_press)
            begin
                handled = 1'b1;
            end
            else
            begin
                // short press while editing; unused button code only restarts timeout and redraws with the field shown
                handled       = 1'b1;
                redraw        = 1'b1;
                idle_cnt_next = '0;
                phase_next    = 1'b1;
                if (mode_reg == wtsc_pkg::MODE_HOURS)
                begin
                    case (button)
                        wtsc_pkg::BTN_UP:
                            hours_next = (hours_reg >= wtsc_pkg::HOURS_MAX) ? '0
                                                                            : hours_reg + 1'b1;
                        wtsc_pkg::BTN_DOWN:
                            hours_next = (hours_reg == '0) ? wtsc_pkg::HOURS_MAX
                                                           : hours_reg - 1'b1;
                        wtsc_pkg::BTN_SELECT:
                            mode_next = wtsc_pkg::MODE_MINUTES;
                        default: ;
                    endcase
                end
                else
                begin
                    case (button)
                        wtsc_pkg::BTN_UP:
                            minutes_next = (minutes_reg >= wtsc_pkg::MINUTES_MAX) ? '0
                                                                    : minutes_reg + 1'b1;
                        wtsc_pkg::BTN_DOWN:
                            minutes_next = (minutes_reg == '0) ? wtsc_pkg::MINUTES_MAX
                                                               : minutes_reg - 1'b1;
                        wtsc_pkg::BTN_SELECT:
                        begin
                            wr            = 1'b1;
                            hold_cnt_next = '0;
                            mode_next     = wtsc_pkg::MODE_CONFIRM;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else
        begin
            case (mode_reg)
                wtsc_pkg::MODE_HOURS, wtsc_pkg::MODE_MINUTES:
                begin
                    idle_cnt_next  = idle_inc;
                    blink_cnt_next = blink_inc;
                    if (idle_fire)
                    begin
                        mode_next = wtsc_pkg::MODE_NORMAL;
                        showc     = 1'b1;
                    end
                    else if (blink_fire)
                    begin
                        phase_next     = ~phase_reg;
                        blink_cnt_next = '0;
                        redraw         = 1'b1;
                    end
                end
                wtsc_pkg::MODE_CONFIRM:
                begin
                    hold_cnt_next = hold_inc;
                    if (hold_fire)
                    begin
                        mode_next = wtsc_pkg::MODE_NORMAL;
                        showc     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        result.handled       = handled;
        result.mode          = mode_next;
        result.shown_hours   = hours_next;
        result.shown_minutes = minutes_next;
        result.blank_hours   = (mode_next == wtsc_pkg::MODE_HOURS) && !phase_next;
        result.blank_minutes = (mode_next == wtsc_pkg::MODE_MINUTES) && !phase_next;
        result.clock_write   = wr;
        result.show_clock    = showc;
        result.redraw        = redraw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= wtsc_pkg::MODE_NORMAL;
            hours_reg     <= '0;
            minutes_reg   <= '0;
            phase_reg     <= 1'b0;
            blink_cnt_reg <= '0;
            idle_cnt_reg  <= '0;
            hold_cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg      <= mode_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            phase_reg     <= phase_next;
            blink_cnt_reg <= blink_cnt_next;
            idle_cnt_reg  <= idle_cnt_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

endmodule

// ===== sv/wtsc_checker.sv =====
// port-level checks on the result channel of the time-set controller
// depends on wtsc_pkg; bound to watch_time_set_controller_unit
module wtsc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic                            res_handled,
    input  logic [1:0]                      res_mode,
    input  logic [wtsc_pkg::HOURS_W-1:0]    res_shown_hours,
    input  logic [wtsc_pkg::MINUTES_W-1:0]  res_shown_minutes,
    input  logic                            res_blank_hours,
    input  logic                            res_blank_minutes,
    input  logic                            res_clock_write,
    input  logic                            res_show_clock,
    input  logic                            res_redraw
);

    // a clock write only ever lands in confirm hold and consumes the button
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_clock_write |->
            res_mode == wtsc_pkg::MODE_CONFIRM && res_handled && !res_show_clock)
        else $error("clock write outside confirm hold");

    // reverting to the real clock comes from a tick and lands in normal mode
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_show_clock |->
            res_mode == wtsc_pkg::MODE_NORMAL && !res_handled && !res_redraw)
        else $error("show clock without return to normal");

    // blanking only in the field being edited, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            !(res_blank_hours && res_blank_minutes) &&
            (!res_blank_hours || res_mode == wtsc_pkg::MODE_HOURS) &&
            (!res_blank_minutes || res_mode == wtsc_pkg::MODE_MINUTES))
        else $error("blanking does not match mode");

    // working time stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            res_shown_hours <= wtsc_pkg::HOURS_MAX &&
            res_shown_minutes <= wtsc_pkg::MINUTES_MAX)
        else $error("working time out of range");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_mode) && $stable(res_shown_hours) &&
            $stable(res_shown_minutes))
        else $error("stalled result changed");

endmodule

bind watch_time_set_controller_unit wtsc_checker u_wtsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_handled       (res.handled),
    .res_mode          (res.mode),
    .res_shown_hours   (res.shown_hours),
    .res_shown_minutes (res.shown_minutes),
    .res_blank_hours   (res.blank_hours),
    .res_blank_minutes (res.blank_minutes),
    .res_clock_write   (res.clock_write),
    .res_show_clock    (res.show_clock),
    .res_redraw        (res.redraw)
);
